// ----- sv/tvc_pkg.sv -----
// Shared types, constants and state encodings of the triaxial vibration conditioner.
package tvc_pkg;

  localparam int unsigned AXES           = 3;
  localparam int unsigned BATCH_SAMPLES  = 512;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned SQRT_RAD_W     = 56;
  localparam int unsigned SQRT_ROOT_W    = SQRT_RAD_W / 2;

  localparam logic [14:0] ALPHA_RESET     = 15'd32113;
  localparam logic [15:0] THRESHOLD_RESET = 16'd50;

  // configuration register indexes
  localparam logic CFG_HPF_ALPHA       = 1'b0;
  localparam logic CFG_STUCK_THRESHOLD = 1'b1;

  typedef struct packed {
    logic signed [11:0] accel_x;
    logic signed [11:0] accel_y;
    logic signed [11:0] accel_z;
    logic               read_ok;
  } in_word_t;

  typedef struct packed {
    logic [22:0] vibration;
    logic        stuck_warning;
    logic        batch_end;
    logic [14:0] rms_x;
    logic [14:0] rms_y;
    logic [14:0] rms_z;
  } out_word_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic [AXES-1:0][11:0] accel;
    logic [AXES-1:0][22:0] sq;
    logic                  warn;
    logic                  bend;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SUM,
    B_MUL,
    B_RND,
    B_SQR,
    B_VIB_GO,
    B_VIB_WAIT,
    B_RMS_GO,
    B_RMS_WAIT,
    B_OUT
  } back_state_t;

endpackage

// ----- sv/tvc_isqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
module tvc_isqrt
  import tvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SQRT_RAD_W-1:0]  radicand,
  output logic                   done,
  output logic [SQRT_ROOT_W-1:0] root
);

  localparam int unsigned CNT_W = $clog2(SQRT_ROOT_W);

  logic [SQRT_RAD_W-1:0]  rad_r;
  logic [SQRT_ROOT_W+1:0] rem_r;
  logic [SQRT_ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [SQRT_ROOT_W+3:0] rem_sh;
  logic [SQRT_ROOT_W+3:0] trial;
  logic                   ge;

  assign rem_sh = {rem_r, rad_r[SQRT_RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(SQRT_ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQRT_RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (SQRT_ROOT_W+2)'(rem_sh - trial) : (SQRT_ROOT_W+2)'(rem_sh);
      root_r <= {root_r[SQRT_ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- sv/tvc_queue.sv -----
// Short word queue between the front and back parts.
module tvc_queue
  import tvc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- sv/tvc_front.sv -----
// Front part: takes samples, squares the axes, tracks the stuck streak and batch position.
module tvc_front
  import tvc_pkg::*;
#(
  parameter int unsigned BATCH = BATCH_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  input  logic [15:0] stuck_threshold,
  output logic        push,
  output job_t        push_data,
  input  logic        q_full
);

  localparam int unsigned POS_W = $clog2(BATCH);

  front_state_t state_r, state_nxt;

  in_word_t              word_r;
  logic [1:0]            ax_r;
  logic [AXES-1:0][22:0] sq_r;
  logic [23:0]           mag_r;
  logic [23:0]           prev_mag_r;
  logic [15:0]           streak_r;
  logic [POS_W-1:0]      pos_r;

  logic signed [11:0] a_sel;
  logic        [23:0] a_sqr;
  logic               stuck_hit;
  logic               warn;
  logic               bend;

  always_comb begin
    case (ax_r)
      2'd0:    a_sel = word_r.accel_x;
      2'd1:    a_sel = word_r.accel_y;
      default: a_sel = word_r.accel_z;
    endcase
  end

  assign a_sqr     = 24'(a_sel * a_sel);
  assign stuck_hit = !word_r.read_ok || (mag_r == prev_mag_r);
  assign warn      = stuck_hit && (streak_r != 16'hFFFF) && (stuck_threshold != '0)
                     && (streak_r + 16'd1 == stuck_threshold);
  assign bend      = pos_r == POS_W'(BATCH - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_SQ;
      F_SQ:    if (ax_r == 2'd2) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_PUSH:  push = !q_full;
      default: ;
    endcase
  end

  assign push_data.accel = {word_r.accel_z, word_r.accel_y, word_r.accel_x};
  assign push_data.sq    = sq_r;
  assign push_data.warn  = warn;
  assign push_data.bend  = bend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      prev_mag_r <= '0;
      streak_r   <= '0;
      pos_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        prev_mag_r <= mag_r;
        if (!stuck_hit) begin
          streak_r <= '0;
        end else if (streak_r != 16'hFFFF) begin
          streak_r <= streak_r + 16'd1;
        end
        pos_r <= bend ? '0 : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
      ax_r   <= '0;
      mag_r  <= '0;
    end else if (state_r == F_SQ) begin
      sq_r[ax_r] <= a_sqr[22:0];
      mag_r      <= mag_r + a_sqr;
      ax_r       <= ax_r + 2'd1;
    end
  end

endmodule

// ----- sv/tvc_back.sv -----
// Back part: per-axis high-pass filters, batch sums, magnitude and RMS roots.
module tvc_back
  import tvc_pkg::*;
#(
  parameter int unsigned BATCH = BATCH_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [14:0] hpf_alpha,
  input  logic        q_empty,
  input  job_t        q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word
);

  localparam int unsigned BATCH_LOG = $clog2(BATCH);

  back_state_t state_r, state_nxt;

  job_t               job_r;
  logic [1:0]         ax_r;
  logic signed [27:0] f_r   [AXES];
  logic signed [11:0] xp_r  [AXES];
  logic        [31:0] sum_r [AXES];
  logic signed [28:0] s_r;
  logic signed [44:0] p_r;
  logic        [27:0] mag_r;
  logic        [55:0] fsum_r;
  logic        [22:0] vib_r;
  logic        [14:0] rms_r [AXES];
  logic               out_valid_r;
  out_word_t          out_r;

  logic                   sq_start;
  logic [SQRT_RAD_W-1:0]  sq_rad;
  logic                   sq_done;
  logic [SQRT_ROOT_W-1:0] sq_root;

  logic signed [11:0] x_cur;
  logic signed [12:0] diff;
  logic signed [28:0] s_val;
  logic               p_neg;
  logic        [44:0] p_mag;
  logic        [29:0] r_mag;
  logic signed [27:0] f_val;
  logic        [27:0] m_val;
  logic        [32:0] sum_add;
  logic               out_free;

  assign x_cur = $signed(job_r.accel[ax_r]);
  assign diff  = $signed({x_cur[11], x_cur}) - $signed({xp_r[ax_r][11], xp_r[ax_r]});
  assign s_val = $signed({f_r[ax_r][27], f_r[ax_r]})
               + $signed({{12{diff[12]}}, diff, 4'b0000});

  // round half away from zero, then clamp to the 28-bit state range
  assign p_neg = p_r[44];
  assign p_mag = p_neg ? 45'(-p_r) : 45'(p_r);
  assign r_mag = 30'((p_mag + 45'd16384) >> 15);

  always_comb begin
    if (!p_neg) begin
      m_val = (r_mag > 30'h7FF_FFFF) ? 28'h7FF_FFFF : r_mag[27:0];
      f_val = $signed(m_val);
    end else begin
      m_val = (r_mag > 30'h800_0000) ? 28'h800_0000 : r_mag[27:0];
      f_val = $signed(28'(-m_val));
    end
  end

  assign sum_add  = {1'b0, sum_r[ax_r]} + {10'b0, job_r.sq[ax_r]};
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:     if (!q_empty) state_nxt = B_SUM;
      B_SUM:      state_nxt = B_MUL;
      B_MUL:      state_nxt = B_RND;
      B_RND:      state_nxt = B_SQR;
      B_SQR:      state_nxt = (ax_r == 2'd2) ? B_VIB_GO : B_SUM;
      B_VIB_GO:   state_nxt = B_VIB_WAIT;
      B_VIB_WAIT: if (sq_done) state_nxt = job_r.bend ? B_RMS_GO : B_OUT;
      B_RMS_GO:   state_nxt = B_RMS_WAIT;
      B_RMS_WAIT: if (sq_done) state_nxt = (ax_r == 2'd2) ? B_OUT : B_RMS_GO;
      B_OUT:      if (out_free) state_nxt = B_IDLE;
      default:    state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    sq_start = 1'b0;
    sq_rad   = fsum_r;
    case (state_r)
      B_IDLE:   pop = !q_empty;
      B_VIB_GO: sq_start = 1'b1;
      B_RMS_GO: begin
        sq_start = 1'b1;
        sq_rad   = {16'b0, sum_r[ax_r], 8'b0} >> BATCH_LOG;
      end
      default: ;
    endcase
  end

  tvc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        f_r[i]   <= '0;
        xp_r[i]  <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_RND: f_r[ax_r] <= f_val;
        B_SQR: begin
          xp_r[ax_r]  <= x_cur;
          sum_r[ax_r] <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
        end
        B_OUT: if (out_free && job_r.bend) begin
          for (int i = 0; i < AXES; i++) sum_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (!q_empty) begin
        job_r  <= q_data;
        ax_r   <= '0;
        fsum_r <= '0;
      end
      B_SUM: s_r   <= s_val;
      B_MUL: p_r   <= s_r * $signed({1'b0, hpf_alpha});
      B_RND: mag_r <= m_val;
      B_SQR: begin
        fsum_r <= fsum_r + 56'(mag_r * mag_r);
        ax_r   <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      B_VIB_WAIT: if (sq_done) begin
        vib_r <= (|sq_root[27:23]) ? 23'h7F_FFFF : sq_root[22:0];
      end
      B_RMS_WAIT: if (sq_done) begin
        rms_r[ax_r] <= (|sq_root[27:15]) ? 15'h7FFF : sq_root[14:0];
        ax_r        <= ax_r + 2'd1;
      end
      B_OUT: if (out_free) begin
        out_r.vibration     <= vib_r;
        out_r.stuck_warning <= job_r.warn;
        out_r.batch_end     <= job_r.bend;
        out_r.rms_x         <= job_r.bend ? rms_r[0] : '0;
        out_r.rms_y         <= job_r.bend ? rms_r[1] : '0;
        out_r.rms_z         <= job_r.bend ? rms_r[2] : '0;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ----- sv/triaxial_vibration_conditioner_unit.sv -----
// Top level of the triaxial vibration conditioner: config registers, front, queue, back.
//
//  channel | ports                              | word
//  --------+------------------------------------+-------------------------------
//  input   | in_valid  in_ready  in_word        | accel x/y/z, read_ok
//  result  | out_valid out_ready out_word       | vibration, warning, batch RMS
//  config  | cfg_valid cfg_ready cfg_index/data | 0: hpf_alpha, 1: stuck_threshold
//
// Front squares the three axes of a sample in turn through one shared 12x12 squarer.
// Back loads a word, filters the three axes in turn (sum, multiply, round, square),
// then takes the magnitude root and hands off; a batch-end word adds three RMS
// roots. The 28-step square root unit is the slowest part.
// Reset (rst_n low, synchronous) clears filters, streak, batch position and sums.
// A two-word queue lets the front take the next sample while the back is busy;
// the back holds a finished word in its output register while out_ready is low.
module triaxial_vibration_conditioner_unit
  import tvc_pkg::*;
#(
  parameter int unsigned BATCH = BATCH_SAMPLES,
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [14:0] alpha_r;
  logic [15:0] thresh_r;

  logic push;
  job_t push_data;
  logic pop;
  job_t pop_data;
  logic q_full;
  logic q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RESET;
      thresh_r <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HPF_ALPHA:       alpha_r  <= cfg_data[14:0];
        CFG_STUCK_THRESHOLD: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tvc_front #(.BATCH(BATCH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .stuck_threshold (thresh_r),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  tvc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tvc_back #(.BATCH(BATCH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hpf_alpha (alpha_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
